// File: rtl/core/sk2_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sk2_pkg: shared types and constants
// Payload structs, the job record passed from front to back, and the kernel
// constants of the sharpened two-to-one decimator.
// ----------------------------------------------------------------------------
package sk2_pkg;

	localparam int TAPS  = 8;
	localparam int WIN   = 7;
	localparam int SUM_W = 15;

	localparam logic [2:0] WARM = 3'd4;

	localparam logic signed [SUM_W-1:0] K_CENTER = 15'sd17;
	localparam logic signed [SUM_W-1:0] K_NEAR   = 15'sd3;
	localparam logic signed [SUM_W-1:0] K_MID    = -15'sd3;
	localparam logic signed [SUM_W-1:0] K_OUTER  = -15'sd1;
	localparam logic signed [SUM_W-1:0] ROUND    = 15'sd16;
	localparam int                      SHIFT    = 5;
	localparam logic signed [SUM_W-1:0] MAX_OUT  = 15'sd255;

	typedef struct packed {
		logic [7:0] sample;
		logic       final_sample;
	} sample_t;

	typedef struct packed {
		logic [7:0] decimated;
		logic       final_result;
	} result_t;

	typedef struct packed {
		logic [TAPS-1:0][7:0] taps;
		logic                 final_result;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// File: rtl/core/sk2_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sk2_front: sample window and job issue
// Keeps the seven-sample window, warm-up count and phase, fills the window on
// the first sample, pads the right edge after the last one, and issues one
// filter job for every push that completes a result.
// ----------------------------------------------------------------------------
module sk2_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire sk2_pkg::sample_t     sample_data,
	input  wire sk2_pkg::q_status_t   q_status,
	output logic                      job_push,
	output sk2_pkg::job_t             job_data
);
	import sk2_pkg::*;

	typedef enum logic [1:0] {
		FRONT_STREAM = 2'b01,
		FRONT_FLUSH  = 2'b10
	} front_state_t;

	front_state_t          state_q;
	logic [WIN-1:0][7:0]   window_q;
	logic [2:0]            count_q;
	logic                  phase_q;
	logic [1:0]            pad_q;
	logic [7:0]            last_q;

	logic                  take;
	logic                  advance;
	logic                  flushing;
	logic [7:0]            x;
	logic [WIN-1:0][7:0]   base;

	always_comb begin
		flushing     = (state_q == FRONT_FLUSH);
		sample_stall = flushing || q_status.full;
		take         = sample_valid && !sample_stall;
		advance      = take || (flushing && !q_status.full);
		x            = flushing ? last_q : sample_data.sample;
		base         = (count_q == 3'd0) ? {WIN{x}} : window_q;
		job_push     = advance && (count_q >= WARM) && !phase_q;
		job_data.taps         = {x, base};
		job_data.final_result = flushing && pad_q[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRONT_STREAM;
			count_q <= 3'd0;
			phase_q <= 1'b0;
			pad_q   <= 2'd0;
		end else begin
			if (advance) begin
				if (flushing && pad_q == 2'd3) begin
					count_q <= 3'd0;
					phase_q <= 1'b0;
				end else begin
					count_q <= (count_q < WARM) ? count_q + 3'd1 : count_q;
					phase_q <= ~phase_q;
				end
			end
			unique case (state_q)
				FRONT_STREAM: begin
					if (take && sample_data.final_sample) begin
						state_q <= FRONT_FLUSH;
						pad_q   <= 2'd0;
					end
				end
				FRONT_FLUSH: begin
					if (advance) begin
						pad_q <= pad_q + 2'd1;
						if (pad_q == 2'd3) begin
							state_q <= FRONT_STREAM;
						end
					end
				end
				default: begin
					state_q <= FRONT_STREAM;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			window_q <= {x, base[WIN-1:1]};
		end
		if (take) begin
			last_q <= sample_data.sample;
		end
	end

`ifndef SYNTHESIS
	a_final_only_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(job_push && job_data.final_result) |-> (state_q == FRONT_FLUSH))
		else $error("final job issued outside the right-edge flush");

	a_flush_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(flushing && advance && pad_q == 2'd3) |=> (count_q == 3'd0 && !phase_q))
		else $error("state not cleared after the flush");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sk2_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sk2_queue: job queue
// Short register queue between the front and the back, so that an output
// stall does not reach the sample window until the queue fills.
// ----------------------------------------------------------------------------
module sk2_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire sk2_pkg::job_t       push_data,
	input  wire logic                pop,
	output sk2_pkg::job_t            pop_data,
	output sk2_pkg::q_status_t       status
);
	import sk2_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t           mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	always_comb begin
		pop_data     = mem_q[rd_q];
		status.full  = (cnt_q == CW'(DEPTH));
		status.empty = (cnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("job pushed into a full queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sk2_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sk2_back: kernel arithmetic and output
// Two-stage pipeline: the first stage forms the rounded kernel sum from the
// eight taps of a job, the second shifts, clamps and holds the result.
// ----------------------------------------------------------------------------
module sk2_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sk2_pkg::q_status_t  q_status,
	input  wire sk2_pkg::job_t       pop_data,
	output logic                     pop,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output sk2_pkg::result_t         result_data
);
	import sk2_pkg::*;

	logic                     en;
	logic [8:0]               p_center;
	logic [8:0]               p_near;
	logic [8:0]               p_mid;
	logic [8:0]               p_outer;
	logic signed [SUM_W-1:0]  sum_next;
	logic signed [SUM_W-1:0]  shifted;
	logic [7:0]               clamped;

	logic                     vld_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic                     final_s1;
	logic                     vld_s2;
	result_t                  res_s2;

	always_comb begin
		en  = !vld_s2 || !result_stall;
		pop = en && !q_status.empty;

		p_center = {1'b0, pop_data.taps[3]} + {1'b0, pop_data.taps[4]};
		p_near   = {1'b0, pop_data.taps[2]} + {1'b0, pop_data.taps[5]};
		p_mid    = {1'b0, pop_data.taps[1]} + {1'b0, pop_data.taps[6]};
		p_outer  = {1'b0, pop_data.taps[0]} + {1'b0, pop_data.taps[7]};
		sum_next = K_CENTER * $signed(SUM_W'(p_center))
		         + K_NEAR   * $signed(SUM_W'(p_near))
		         + K_MID    * $signed(SUM_W'(p_mid))
		         + K_OUTER  * $signed(SUM_W'(p_outer))
		         + ROUND;

		shifted = sum_s1 >>> SHIFT;
		if (shifted < 0) begin
			clamped = 8'd0;
		end else if (shifted > MAX_OUT) begin
			clamped = 8'd255;
		end else begin
			clamped = shifted[7:0];
		end

		result_valid = vld_s2;
		result_data  = res_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1              <= sum_next;
			final_s1            <= pop_data.final_result;
			res_s2.decimated    <= clamped;
			res_s2.final_result <= final_s1;
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from an empty queue");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && result_stall) |=> ($stable(vld_s1) && (!vld_s1 || $stable(final_s1))))
		else $error("first stage moved during an output stall");
`endif

endmodule
`default_nettype wire

// File: rtl/core/sharp_kernel_decimate_by_two_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sharp_kernel_decimate_by_two_unit: two-to-one sharpened-kernel decimator
// Filters a byte stream with the kernel -1,-3,3,17,17,3,-3,-1 and keeps every
// second result, with edge replication at both ends of each array.
// ----------------------------------------------------------------------------
//  channel   valid          stall          payload
//  input     sample_valid   sample_stall   sample_data  (sample, final_sample)
//  output    result_valid   result_stall   result_data  (decimated, final_result)
//
//  One sample is taken per cycle while the job queue has room and no right-edge padding is under way.
//  A final sample is followed by right-edge padding in the front, which repeats the last sample,
//  during which sample_stall is high; the next array starts after it.
//  A result passes from the queue through the kernel-sum register and then the output register of the back pipeline.
//  An output stall fills the QUEUE_DEPTH-entry queue before it stalls input.
//  Reset clears the control state only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sharp_kernel_decimate_by_two_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire sk2_pkg::sample_t   sample_data,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output sk2_pkg::result_t        result_data
);
	import sk2_pkg::*;

	logic       job_push;
	job_t       job_data;
	logic       job_pop;
	job_t       pop_data;
	q_status_t  q_status;

	sk2_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data),
		.q_status     (q_status),
		.job_push     (job_push),
		.job_data     (job_data)
	);

	sk2_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_data),
		.pop       (job_pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	sk2_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.pop_data     (pop_data),
		.pop          (job_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule
`default_nettype wire
